@@ rtl/voice_sysex_frame_builder_assert.svh @@
// Assertion macros for the voice SysEx frame builder.
// Used by the front, queue and back modules; no other dependencies.
`ifndef VOICE_SYSEX_FRAME_BUILDER_ASSERT_SVH
`define VOICE_SYSEX_FRAME_BUILDER_ASSERT_SVH
`ifndef SYNTHESIS
`define VSFB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
`define VSFB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VSFB_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define VSFB_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ rtl/vsfb_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, frame constants and byte conversion rules of the voice SysEx builder.
// No dependencies.
package vsfb_pkg;

  localparam logic [7:0] SYX_START  = 8'hF0;
  localparam logic [7:0] MFR_ID     = 8'h43;
  localparam logic [7:0] FMT_VCED   = 8'h03;
  localparam logic [7:0] CNT_MSB    = 8'h00;
  localparam logic [7:0] CNT_LSB    = 8'h5D;
  localparam logic [7:0] SYX_END    = 8'hF7;
  localparam logic [7:0] RULE_CLAMP = 8'hFF;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [6:0] POS_LAST     = 7'd92;
  localparam logic [6:0] POS_COMMON   = 7'd52;
  localparam logic [6:0] POS_NAME     = 7'd77;
  localparam logic [6:0] POS_NAME_END = 7'd87;
  localparam logic [3:0] OP_OFF_LAST  = 4'd12;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] chk;
    logic       hdr;
    logic       trl;
  } q_entry_t;

  // mask per byte of an operator group
  function automatic logic [7:0] op_rule(input logic [3:0] off);
    logic [7:0] r;
    unique case (off) inside
      4'd0, 4'd1, 4'd2: r = 8'h1F;
      4'd3, 4'd4:       r = 8'h0F;
      4'd6:             r = 8'h03;
      4'd7, 4'd9, 4'd12: r = 8'h07;
      4'd8:             r = 8'h01;
      4'd11:            r = 8'h3F;
      default:          r = RULE_CLAMP;
    endcase
    return r;
  endfunction

  // mask per common byte, offset from the first common position
  function automatic logic [7:0] common_rule(input logic [4:0] off);
    logic [7:0] r;
    unique case (off) inside
      5'd0, 5'd1, 5'd8:                   r = 8'h07;
      5'd6, 5'd11, 5'd13, 5'd16, 5'd17, 5'd18: r = 8'h01;
      5'd7, 5'd9:                         r = 8'h03;
      default:                            r = RULE_CLAMP;
    endcase
    return r;
  endfunction

  function automatic logic [6:0] sat7(input logic signed [15:0] v);
    logic [6:0] r;
    if (v[15]) r = 7'd0;
    else if (|v[14:7]) r = 7'd127;
    else r = v[6:0];
    return r;
  endfunction

  function automatic logic [7:0] apply_rule(input logic [7:0] rule,
                                            input logic signed [15:0] v);
    logic [7:0] r;
    if (rule == RULE_CLAMP) r = {1'b0, sat7(v)};
    else r = v[7:0] & rule;
    return r;
  endfunction

endpackage

@@ rtl/voice_sysex_frame_builder.sv @@
`timescale 1ns / 1ps
// Top level of the voice-dump SysEx frame builder: device register, front end,
// queue and back end. Depends on vsfb_pkg, vsfb_front, vsfb_queue, vsfb_back.
//
// Takes 93 voice parameter values in wire order and emits one 101-byte frame
// (F0 43 dev 03 00 5D, 93 data bytes, checksum, F7 with last set). A value
// normally produces one output beat; the first of a frame produces seven and the
// last three. The output register sends one byte per cycle while out_stall is
// low; the front end takes one value per cycle while the QUEUE_DEPTH-entry queue
// has room. The first byte passes through the queue and then the output register
// before it is presented.
// device_number is captured on a cfg write and read when the header is sent; write it between frames.
module voice_sysex_frame_builder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [3:0]         device_number,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] value,
  input  logic               pad,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         byte_res,
  output logic               last
);

  logic [3:0]          dev;
  logic                push, full, pop, head_valid;
  vsfb_pkg::q_entry_t  push_data, head;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) dev <= 4'd0;
    else if (cfg_valid && cfg_ready) dev <= device_number;
  end

  vsfb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .value     (value),
    .pad       (pad),
    .q_full    (full),
    .push      (push),
    .push_data (push_data)
  );

  vsfb_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  vsfb_back u_back (
    .clk        (clk),
    .rst        (rst),
    .dev        (dev),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .byte_res   (byte_res),
    .last       (last)
  );

endmodule

@@ rtl/vsfb_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts parameter values, converts each to its data byte, keeps the
// frame position and running checksum. Depends on vsfb_pkg.
`include "voice_sysex_frame_builder_assert.svh"
module vsfb_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [15:0]      value,
  input  logic                    pad,
  input  logic                    q_full,
  output logic                    push,
  output vsfb_pkg::q_entry_t      push_data
);

  logic [6:0] pos;
  logic [3:0] op_off;
  logic [6:0] sum;
  logic [6:0] pos_next;
  logic [3:0] op_off_next;
  logic [6:0] sum_next;

  logic       is_op, is_com, is_name;
  logic [7:0] rule;
  logic [7:0] data;
  logic [6:0] sum_base;
  logic [6:0] sum_new;
  logic       frame_end;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  assign is_op   = pos < vsfb_pkg::POS_COMMON;
  assign is_com  = !is_op && (pos < vsfb_pkg::POS_NAME);
  assign is_name = (pos >= vsfb_pkg::POS_NAME) && (pos < vsfb_pkg::POS_NAME_END);
  assign frame_end = pos == vsfb_pkg::POS_LAST;

  always_comb begin
    rule = is_op ? vsfb_pkg::op_rule(op_off)
                 : vsfb_pkg::common_rule(5'(pos - vsfb_pkg::POS_COMMON));
    if (is_op || is_com) data = vsfb_pkg::apply_rule(rule, value);
    else if (is_name) data = pad ? vsfb_pkg::CHAR_SPACE : value[7:0];
    else data = {1'b0, vsfb_pkg::sat7(value)};
  end

  assign sum_base = (pos == 7'd0) ? 7'd0 : sum;
  assign sum_new  = sum_base + data[6:0];

  always_comb begin
    push_data.data = data;
    push_data.chk  = 7'd0 - sum_new;
    push_data.hdr  = pos == 7'd0;
    push_data.trl  = frame_end;
  end

  always_comb begin
    pos_next    = pos;
    op_off_next = op_off;
    sum_next    = sum;
    if (push) begin
      pos_next    = frame_end ? 7'd0 : pos + 7'd1;
      op_off_next = (frame_end || op_off == vsfb_pkg::OP_OFF_LAST) ? 4'd0 : op_off + 4'd1;
      sum_next    = frame_end ? 7'd0 : sum_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= 7'd0;
      op_off <= 4'd0;
      sum    <= 7'd0;
    end else begin
      pos    <= pos_next;
      op_off <= op_off_next;
      sum    <= sum_next;
    end
  end

  `VSFB_ASSERT_IMP(a_pos_range, clk, rst, 1'b1, pos <= vsfb_pkg::POS_LAST, "position past frame end")
  `VSFB_ASSERT_NXT(a_wrap, clk, rst, push && frame_end, pos == 7'd0 && op_off == 4'd0, "frame did not wrap")

endmodule

@@ rtl/vsfb_queue.sv @@
`timescale 1ns / 1ps
// Small register queue between front and back ends.
// Depends on vsfb_pkg for the entry type.
`include "voice_sysex_frame_builder_assert.svh"
module vsfb_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  vsfb_pkg::q_entry_t  push_data,
  output logic                full,
  input  logic                pop,
  output logic                head_valid,
  output vsfb_pkg::q_entry_t  head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  vsfb_pkg::q_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] cnt;

  assign full       = cnt == CNT_FULL;
  assign head_valid = cnt != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) cnt <= cnt + CW'(1);
      else if (pop && !push) cnt <= cnt - CW'(1);
    end
  end

  `VSFB_ASSERT_IMP(a_no_overflow, clk, rst, full, !push, "push into full queue")

endmodule

@@ rtl/vsfb_back.sv @@
`timescale 1ns / 1ps
// Back end: serializes each queued entry into header, data and trailer bytes
// through a registered output stage. Depends on vsfb_pkg.
`include "voice_sysex_frame_builder_assert.svh"
module vsfb_back (
  input  logic                clk,
  input  logic                rst,
  input  logic [3:0]          dev,
  input  logic                head_valid,
  input  vsfb_pkg::q_entry_t  head,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          byte_res,
  output logic                last
);

  typedef enum logic [3:0] {
    PH_START, PH_H0, PH_H1, PH_H2, PH_H3, PH_H4, PH_H5, PH_DATA, PH_CHK, PH_END
  } phase_t;

  phase_t     phase, cur, nxt;
  logic       out_load, step;
  logic [7:0] b;
  logic       b_last;

  assign out_load = !out_valid || !out_stall;
  assign step     = head_valid && out_load;

  always_comb begin
    cur = phase;
    if (phase == PH_START) cur = head.hdr ? PH_H0 : PH_DATA;
  end

  always_comb begin
    b_last = 1'b0;
    nxt    = PH_START;
    pop    = 1'b0;
    b      = head.data;
    unique case (cur)
      PH_H0:   begin b = vsfb_pkg::SYX_START; nxt = PH_H1; end
      PH_H1:   begin b = vsfb_pkg::MFR_ID;    nxt = PH_H2; end
      PH_H2:   begin b = {4'd0, dev};         nxt = PH_H3; end
      PH_H3:   begin b = vsfb_pkg::FMT_VCED;  nxt = PH_H4; end
      PH_H4:   begin b = vsfb_pkg::CNT_MSB;   nxt = PH_H5; end
      PH_H5:   begin b = vsfb_pkg::CNT_LSB;   nxt = PH_DATA; end
      PH_DATA: begin
        b   = head.data;
        nxt = head.trl ? PH_CHK : PH_START;
        pop = step && !head.trl;
      end
      PH_CHK:  begin b = {1'b0, head.chk};    nxt = PH_END; end
      PH_END:  begin
        b      = vsfb_pkg::SYX_END;
        b_last = 1'b1;
        nxt    = PH_START;
        pop    = step;
      end
      default: begin b = head.data; nxt = PH_START; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_START;
      out_valid <= 1'b0;
      last      <= 1'b0;
      byte_res  <= 8'd0;
    end else begin
      if (step) begin
        phase    <= nxt;
        byte_res <= b;
      end
      if (out_load) begin
        out_valid <= head_valid;
        last      <= b_last && head_valid;
      end
    end
  end

  `VSFB_ASSERT_IMP(a_last_is_end, clk, rst, out_valid && last, byte_res == vsfb_pkg::SYX_END, "last on a byte other than F7")

endmodule

@@ tb/voice_sysex_frame_builder_check.sv @@
`timescale 1ns / 1ps
// Scoreboard for the voice SysEx frame builder: tracks the frame position, checksum and
// device register, predicts every frame byte and compares output beats. Depends on vsfb_pkg.
module voice_sysex_frame_builder_check
  import vsfb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [3:0]         device_number,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] value,
  input  logic               pad,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic [7:0]         byte_res,
  input  logic               last,
  output int                 mismatches,
  output int                 pending
);

  // keep masks, entry k at bits [8k +: 8]; RULE_CLAMP marks a saturated byte
  localparam logic [103:0] OP_KEEP = {
    8'h07, 8'h3F, RULE_CLAMP, 8'h07, 8'h01, 8'h07, 8'h03, RULE_CLAMP,
    8'h0F, 8'h0F, 8'h1F, 8'h1F, 8'h1F
  };
  localparam logic [199:0] COMMON_KEEP = {
    RULE_CLAMP, RULE_CLAMP, RULE_CLAMP, RULE_CLAMP, RULE_CLAMP, RULE_CLAMP,
    8'h01, 8'h01, 8'h01, RULE_CLAMP, RULE_CLAMP, 8'h01, RULE_CLAMP, 8'h01,
    RULE_CLAMP, 8'h03, 8'h07, 8'h03, 8'h01,
    RULE_CLAMP, RULE_CLAMP, RULE_CLAMP, RULE_CLAMP, 8'h07, 8'h07
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last_beat;
  } frame_beat_t;

  frame_beat_t frame_bytes_q[$];
  logic [3:0]  device_reg;
  logic [6:0]  frame_pos;
  logic [6:0]  frame_sum;

  function automatic logic [7:0] data_byte_for(input logic [6:0] p,
                                               input logic signed [15:0] v,
                                               input logic pd);
    logic [7:0] keep;
    logic [7:0] sat;
    if (v < 0) sat = 8'd0;
    else if (v > 16'sd127) sat = 8'd127;
    else sat = {1'b0, v[6:0]};
    if (p < POS_COMMON) keep = OP_KEEP[(p % 13) * 8 +: 8];
    else if (p < POS_NAME) keep = COMMON_KEEP[(p - POS_COMMON) * 8 +: 8];
    else if (p < POS_NAME_END) return pd ? CHAR_SPACE : v[7:0];
    else keep = RULE_CLAMP;
    return (keep == RULE_CLAMP) ? sat : (v[7:0] & keep);
  endfunction

  task automatic expect_beat(input logic [7:0] d, input logic fin);
    frame_beat_t nb;
    nb.data = d;
    nb.last_beat = fin;
    frame_bytes_q = {frame_bytes_q, nb};
  endtask

  task automatic predict_frame_bytes(input logic signed [15:0] v, input logic pd);
    logic [7:0] b;
    if (frame_pos == 7'd0) begin
      expect_beat(SYX_START, 1'b0);
      expect_beat(MFR_ID, 1'b0);
      expect_beat({4'h0, device_reg}, 1'b0);
      expect_beat(FMT_VCED, 1'b0);
      expect_beat(CNT_MSB, 1'b0);
      expect_beat(CNT_LSB, 1'b0);
      frame_sum = 7'd0;
    end
    b = data_byte_for(frame_pos, v, pd);
    expect_beat(b, 1'b0);
    frame_sum = frame_sum + b[6:0];
    if (frame_pos == POS_LAST) begin
      // checksum makes the 7-bit sum of data bytes and checksum come out to zero
      expect_beat({1'b0, 7'd0 - frame_sum}, 1'b0);
      expect_beat(SYX_END, 1'b1);
      frame_pos = 7'd0;
      frame_sum = 7'd0;
    end else begin
      frame_pos = frame_pos + 7'd1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t: %s", $time, msg);
    mismatches++;
  endtask

  initial begin
    mismatches = 0;
    pending = 0;
    device_reg = 4'h0;
    frame_pos = 7'd0;
    frame_sum = 7'd0;
  end

  always @(posedge clk) begin
    frame_beat_t want;
    if (rst) begin
      device_reg = 4'h0;
      frame_pos = 7'd0;
      frame_sum = 7'd0;
      frame_bytes_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) device_reg = device_number;
      if (in_valid && !in_stall) predict_frame_bytes(value, pad);
      if (out_valid && !out_stall) begin
        if (frame_bytes_q.size() == 0) begin
          report_mismatch($sformatf("unexpected beat: byte_res %02h last %0b", byte_res, last));
        end else begin
          want = frame_bytes_q.pop_front();
          if (byte_res !== want.data)
            report_mismatch($sformatf("byte_res %02h, want %02h", byte_res, want.data));
          if (last !== want.last_beat)
            report_mismatch($sformatf("last %0b, want %0b on byte %02h", last,
                                      want.last_beat, want.data));
        end
      end
    end
    pending = frame_bytes_q.size();
  end

endmodule

@@ tb/voice_sysex_frame_builder_test.sv @@
`timescale 1ns / 1ps
// Testbench top for the voice SysEx frame builder: clock, reset, stimulus and verdict.
// Depends on vsfb_pkg, voice_sysex_frame_builder and voice_sysex_frame_builder_check.
module voice_sysex_frame_builder_test;
  import vsfb_pkg::*;

  localparam int IDLE_LIMIT   = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 99;
  // 7FFF, 8000, 0000, FFFF, 007F, 0080, 00FF from entry 0 up
  localparam logic [111:0] CORNERS = {
    16'h00FF, 16'h0080, 16'h007F, 16'hFFFF, 16'h0000, 16'h8000, 16'h7FFF
  };

  logic               clk;
  logic               rst;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [3:0]         device_number;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] value;
  logic               pad;
  logic               out_valid;
  logic               out_stall;
  logic [7:0]         byte_res;
  logic               last;

  int         mismatches;
  int         pending;
  int         src_gap_pct;
  int         dst_stall_pct;
  int         idle_cycles;
  int         name_len;
  logic [6:0] stim_pos;

  voice_sysex_frame_builder DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .device_number(device_number),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .pad(pad),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .byte_res(byte_res),
    .last(last)
  );

  voice_sysex_frame_builder_check frame_check (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .device_number(device_number),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .value(value),
    .pad(pad),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .byte_res(byte_res),
    .last(last),
    .mismatches(mismatches),
    .pending(pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < dst_stall_pct);
  end

  // watchdog: any beat on any channel restarts the count
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IDLE_LIMIT) begin
      $display("voice_sysex_frame_builder_test failed");
      $finish;
    end
  end

  task automatic send_item(input logic signed [15:0] v, input logic pd);
    @(negedge clk);
    while ($urandom_range(99) < src_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    pad <= pd;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    stim_pos = (stim_pos == POS_LAST) ? 7'd0 : stim_pos + 7'd1;
  endtask

  task automatic send_random_item;
    logic signed [15:0] v;
    logic               pd;
    int                 pick;
    if (stim_pos == 7'd0) name_len = $urandom_range(10);
    pick = $urandom_range(9);
    if (pick < 3) v = 16'($urandom);
    else if (pick < 5) v = 16'($urandom_range(255));
    else if (pick < 7) v = 16'($urandom_range(140));   // around the saturation edge
    else if (pick < 8) v = -16'($urandom_range(200));
    else v = CORNERS[$urandom_range(6) * 16 +: 16];
    pd = 1'($urandom_range(1));
    if (stim_pos >= POS_NAME && stim_pos < POS_NAME_END) begin
      if (pick >= 3 && pick < 8) v = 16'($urandom_range(32, 126));
      // pad the tail of the name, with an occasional stray flag
      pd = (stim_pos - POS_NAME >= name_len);
      if ($urandom_range(15) == 0) pd = ~pd;
    end
    send_item(v, pd);
  endtask

  task automatic write_device(input logic [3:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    device_number <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    int i;
    int phase;
    rst = 1'b1;
    cfg_valid = 1'b0;
    device_number = 4'h0;
    in_valid = 1'b0;
    value = 16'sd0;
    pad = 1'b0;
    out_stall = 1'b0;
    src_gap_pct = 14;
    dst_stall_pct = 56;
    stim_pos = 7'd0;
    name_len = 10;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corner values over the first operator bytes, pad toggling
    write_device(4'hF);
    for (i = 0; i < 24; i++) send_item(CORNERS[(i % 7) * 16 +: 16], i[0]);
    drain;

    for (phase = 0; phase < 3; phase++) begin
      src_gap_pct = (phase == 0) ? 14 : (phase == 1) ? 56 : 0;
      dst_stall_pct = (phase == 0) ? 56 : (phase == 1) ? 14 : 0;
      write_device((phase == 0) ? 4'h0 : 4'($urandom_range(1, 14)));
      for (i = 0; i < PHASE_ITEMS; i++) send_random_item;
      drain;
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("voice_sysex_frame_builder_test passed");
    end else begin
      $display("voice_sysex_frame_builder_test failed");
    end
    $finish;
  end

endmodule
